@@ rtl/mdio22_pkg.sv @@
// package: beat types and command codes for the clause-22 mdio master
package mdio22_pkg;

    // command codes carried in func
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // fixed frame field widths
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 16;

    // frame codes
    localparam logic [1:0] ST_CODE  = 2'b01;
    localparam logic [1:0] OP_WRITE = 2'b01;
    localparam logic [1:0] OP_READ  = 2'b10;
    localparam logic [1:0] TA_WRITE = 2'b10;

    // one input beat
    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] reg_addr;
        logic [DATA_W-1:0] write_data;
        logic              mdio_in;
    } mdio22_in_t;

    // one result beat
    typedef struct packed {
        logic              mdc;
        logic              mdio_out;
        logic              mdio_drive;
        logic              busy_res;
        logic              done_res;
        logic [DATA_W-1:0] read_data;
        logic              read_error;
        logic              rejected;
    } mdio22_out_t;

endpackage

@@ rtl/mdio_clause22_master.sv @@
// top level: clause-22 mdio master with tick-driven frame sequencer
//
// input channel (in_valid / in_stall / in_item) carries one beat per command or
// half-period tick: func 0 starts a read, 1 starts a write, 2 advances mdc by one
// half period. every accepted beat yields exactly one result beat on the output
// channel (out_valid / out_stall / out_item) with the bus levels, busy, done,
// read data and status after that beat.
// each result beat is registered in the result buffer before out_valid; one beat per
// cycle is sustained while the output is not stalled.
// a two-entry result buffer sits before the output; in_stall rises only when
// both entries are held by a stalled receiver.
// the phy address register is written through cfg_valid / cfg_data and is
// always ready; write it only while no transaction runs.
// reset clears the sequencer to idle: mdc low, mdio released, read data zero,
// phy address zero, and empties the result buffer.
// a write frame takes 2*(PREAMBLE_BITS+32)+2 ticks after the start beat; a read
// takes 2*(PREAMBLE_BITS+31)+1 ticks, or ends early on a bad turnaround bit.
module mdio_clause22_master #(
    parameter int unsigned PREAMBLE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  mdio22_pkg::mdio22_in_t            in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output mdio22_pkg::mdio22_out_t           out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mdio22_pkg::ADDR_W-1:0]     cfg_data
);
    import mdio22_pkg::*;

    logic        step;
    logic        full;
    mdio22_out_t result;

    assign in_stall  = full;
    assign step      = in_valid && !full;
    assign cfg_ready = 1'b1;

    // frame sequencer
    mdio22_core #(
        .PREAMBLE_BITS (PREAMBLE_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .in_item  (in_item),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .result   (result)
    );

    // result buffer
    mdio22_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_item (result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

@@ rtl/mdio22_core.sv @@
// frame sequencer: command decode, frame shifter, half-period counter, read capture
module mdio22_core #(
    parameter int unsigned PREAMBLE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  mdio22_pkg::mdio22_in_t              in_item,
    input  logic                                cfg_we,
    input  logic [mdio22_pkg::ADDR_W-1:0]       cfg_data,
    output mdio22_pkg::mdio22_out_t             result
);
    import mdio22_pkg::*;

    localparam int unsigned FRAME_W  = PREAMBLE_BITS + 32;
    localparam logic [7:0]  READ_DRV = 8'(PREAMBLE_BITS + 14);
    localparam logic [7:0]  READ_TA  = 8'(PREAMBLE_BITS + 15);
    localparam logic [7:0]  READ_END = 8'(PREAMBLE_BITS + 31);
    localparam logic [7:0]  WR_TOT   = 8'(PREAMBLE_BITS + 32);
    localparam logic [7:0]  WR_END   = 8'(2 * (PREAMBLE_BITS + 32) + 1);

    logic [ADDR_W-1:0]  phy_reg;
    logic [7:0]         half_reg,   half_next;
    logic [FRAME_W-1:0] frame_reg,  frame_next;
    logic               is_read_reg, is_read_next;
    logic               active_reg, active_next;
    logic [DATA_W-1:0]  shift_reg,  shift_next;
    logic               clk_lvl_reg, clk_lvl_next;
    logic               level_reg,  level_next;
    logic               own_reg,    own_next;
    logic [DATA_W-1:0]  last_reg,   last_next;
    logic               err_reg,    err_next;
    logic               done;
    logic               rej;
    logic [7:0]         bit_idx;
    logic [DATA_W-1:0]  shifted;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phy_reg <= '0;
        end
        else if (cfg_we)
        begin
            phy_reg <= cfg_data;
        end
    end

    assign bit_idx = {1'b0, half_reg[7:1]};
    assign shifted = {shift_reg[DATA_W-2:0], in_item.mdio_in};

    // next state for one beat
    always_comb
    begin
        half_next    = half_reg;
        frame_next   = frame_reg;
        is_read_next = is_read_reg;
        active_next  = active_reg;
        shift_next   = shift_reg;
        clk_lvl_next = clk_lvl_reg;
        level_next   = level_reg;
        own_next     = own_reg;
        last_next    = last_reg;
        err_next     = err_reg;
        done         = 1'b0;
        rej          = 1'b0;
        if (step)
        begin
            unique case (in_item.func)
                FUNC_READ, FUNC_WRITE:
                begin
                    if (active_reg)
                    begin
                        rej = 1'b1;
                    end
                    else
                    begin
                        if (in_item.func == FUNC_READ)
                        begin
                            frame_next = {{PREAMBLE_BITS{1'b1}}, ST_CODE, OP_READ, phy_reg,
                                          in_item.reg_addr, 18'b0};
                        end
                        else
                        begin
                            frame_next = {{PREAMBLE_BITS{1'b1}}, ST_CODE, OP_WRITE, phy_reg,
                                          in_item.reg_addr, TA_WRITE, in_item.write_data};
                        end
                        is_read_next = (in_item.func == FUNC_READ);
                        active_next  = 1'b1;
                        half_next    = '0;
                        shift_next   = '0;
                        clk_lvl_next = 1'b0;
                        level_next   = 1'b1;
                        own_next     = 1'b1;
                        err_next     = 1'b0;
                    end
                end
                FUNC_TICK:
                begin
                    if (active_reg)
                    begin
                        half_next = half_reg + 8'd1;
                        if (is_read_reg)
                        begin
                            if (half_reg[0])
                            begin
                                clk_lvl_next = 1'b1;
                            end
                            else
                            begin
                                clk_lvl_next = 1'b0;
                                if (bit_idx == READ_TA && in_item.mdio_in)
                                begin
                                    err_next = 1'b1;
                                    done     = 1'b1;
                                end
                                else if (bit_idx > READ_TA)
                                begin
                                    shift_next = shifted;
                                    if (bit_idx >= READ_END)
                                    begin
                                        last_next = shifted;
                                        done      = 1'b1;
                                    end
                                end
                                if (bit_idx < READ_DRV)
                                begin
                                    level_next = frame_reg[FRAME_W-1];
                                    frame_next = {frame_reg[FRAME_W-2:0], 1'b0};
                                    own_next   = 1'b1;
                                end
                                else
                                begin
                                    level_next = 1'b1;
                                    own_next   = 1'b0;
                                end
                            end
                        end
                        else if (half_reg >= WR_END)
                        begin
                            done = 1'b1;
                        end
                        else if (half_reg[0])
                        begin
                            clk_lvl_next = 1'b1;
                        end
                        else
                        begin
                            clk_lvl_next = 1'b0;
                            own_next     = 1'b1;
                            if (bit_idx < WR_TOT)
                            begin
                                level_next = frame_reg[FRAME_W-1];
                                frame_next = {frame_reg[FRAME_W-2:0], 1'b0};
                            end
                            else
                            begin
                                level_next = 1'b1;
                            end
                        end
                        // end of transaction releases the bus
                        if (done)
                        begin
                            active_next  = 1'b0;
                            clk_lvl_next = 1'b0;
                            level_next   = 1'b1;
                            own_next     = 1'b0;
                            half_next    = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= '0;
            frame_reg   <= '0;
            is_read_reg <= 1'b0;
            active_reg  <= 1'b0;
            shift_reg   <= '0;
            clk_lvl_reg <= 1'b0;
            level_reg   <= 1'b1;
            own_reg     <= 1'b0;
            last_reg    <= '0;
            err_reg     <= 1'b0;
        end
        else
        begin
            half_reg    <= half_next;
            frame_reg   <= frame_next;
            is_read_reg <= is_read_next;
            active_reg  <= active_next;
            shift_reg   <= shift_next;
            clk_lvl_reg <= clk_lvl_next;
            level_reg   <= level_next;
            own_reg     <= own_next;
            last_reg    <= last_next;
            err_reg     <= err_next;
        end
    end

    // result beat reflects state after this item
    always_comb
    begin
        result.mdc        = clk_lvl_next;
        result.mdio_out   = level_next;
        result.mdio_drive = own_next;
        result.busy_res   = active_next;
        result.done_res   = done;
        result.read_data  = last_next;
        result.read_error = err_next;
        result.rejected   = rej;
    end

endmodule

@@ rtl/mdio22_outbuf.sv @@
// result register with a skid slot that takes one more beat under output stall
module mdio22_outbuf (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  mdio22_pkg::mdio22_out_t push_item,
    output logic                    full,
    output logic                    out_valid,
    input  logic                    out_stall,
    output mdio22_pkg::mdio22_out_t out_item
);
    import mdio22_pkg::*;

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    mdio22_out_t main_reg,       main_next;
    mdio22_out_t skid_reg,       skid_next;
    logic        pop;

    assign pop = main_valid_reg && !out_stall;

    // slot steering
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_next       = push_item;
                main_valid_next = 1'b1;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_next       = push_item;
            skid_valid_next = 1'b1;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_item  = main_reg;

endmodule
